>>> sv/assert_macros.svh
// assertion macros used by the checker file hlsa_check.sv
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is active
`define HLSA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, ignored while reset is active
`define HLSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also covers reset cycles
`define HLSA_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/hlsa_pkg.sv
// shared types, constants and helper functions for the hls adjust pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package hlsa_pkg;

    localparam int PIX_W  = 8;
    localparam int PCT_W  = 8;
    localparam int NUM_W  = 17;
    localparam int DEN_W  = 9;
    localparam int QUO_W  = 8;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register index, taken from paddr bit 2
    localparam logic REG_LIGHT = 1'b0;
    localparam logic REG_SAT   = 1'b1;

    // reciprocal constants for division by 100, 85 and 255
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          SHIFT_100 = 19;
    localparam logic [23:0] RECIP_85  = 24'd12632257;
    localparam int          SHIFT_85  = 30;
    localparam logic [17:0] RECIP_255 = 18'd131587;
    localparam int          SHIFT_255 = 25;

    // hue segment of a channel angle
    localparam logic [1:0] SEG_RISE = 2'd0;
    localparam logic [1:0] SEG_TOP  = 2'd1;
    localparam logic [1:0] SEG_FALL = 2'd2;
    localparam logic [1:0] SEG_LOW  = 2'd3;

    typedef logic [PIX_W-1:0] pix_t;

    // divider stage contents
    typedef struct packed {
        pix_t             light;
        logic [NUM_W-1:0] s_rem;
        logic [DEN_W-1:0] s_den;
        logic [QUO_W-1:0] s_quo;
        logic [NUM_W-1:0] h_rem;
        logic [DEN_W-1:0] h_den;
        logic [QUO_W-1:0] h_quo;
    } div_t;

    typedef struct packed {
        pix_t light;
        pix_t sat;
        pix_t hue;
    } hls_t;

    // clamped percentages from the register file
    typedef struct packed {
        logic signed [PCT_W-1:0] light_pct;
        logic signed [PCT_W-1:0] sat_pct;
    } pct_t;

    function automatic logic signed [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] raw);
        logic signed [PCT_W-1:0] v;
        v = signed'(raw);
        if (v > 8'sd100) begin
            return 8'sd100;
        end
        if (v < -8'sd100) begin
            return -8'sd100;
        end
        return v;
    endfunction

    // one restoring division step on both quotients
    function automatic div_t div_step(input div_t x, input logic [2:0] j);
        div_t             y;
        logic [NUM_W-1:0] ds;
        logic [NUM_W-1:0] dh;
        y  = x;
        ds = NUM_W'(x.s_den) << j;
        dh = NUM_W'(x.h_den) << j;
        if (x.s_rem >= ds) begin
            y.s_rem    = x.s_rem - ds;
            y.s_quo[j] = 1'b1;
        end
        if (x.h_rem >= dh) begin
            y.h_rem    = x.h_rem - dh;
            y.h_quo[j] = 1'b1;
        end
        return y;
    endfunction

    // angle in units of 360/255 degrees: 42 ends the rise, 127 the top, 169 the fall
    function automatic logic [1:0] seg_of(input pix_t k);
        if (k <= 8'd42) begin
            return SEG_RISE;
        end
        if (k <= 8'd127) begin
            return SEG_TOP;
        end
        if (k <= 8'd169) begin
            return SEG_FALL;
        end
        return SEG_LOW;
    endfunction

    // distance from the low plateau along a slope
    function automatic logic [5:0] slope_of(input pix_t k);
        pix_t t;
        t = 8'd170 - k;
        return (k <= 8'd42) ? k[5:0] : t[5:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/rgb_hls_lightness_saturation_adjust_top.sv
// top level: register file, rgb->hls front, dividers, adjust and hls->rgb back end
// depends on hlsa_pkg, hlsa_front, hlsa_div, hlsa_adjust, hlsa_back
//
// channel   handshake          payload
// s_        s_valid / s_ready  s_in_red, s_in_green, s_in_blue
// m_        m_valid / m_ready  m_out_red, m_out_green, m_out_blue
// apb       psel / penable     paddr, pwrite, pwdata, prdata, pready
//
// one pixel per clock sustained while m_ready is high; a pixel passes through
// 18 register stages: 1 front, 8 divider, 2 adjust, 7 back end
// synchronous active-low reset clears all valid bits and both percent registers
// a stall on m_ready fills bubbles first; s_ready drops only when every stage is full
`default_nettype none

module rgb_hls_lightness_saturation_adjust_top (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [hlsa_pkg::ADDR_W-1:0]     paddr,
    input  wire [hlsa_pkg::DATA_W-1:0]     pwdata,
    output logic [hlsa_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire hlsa_pkg::pix_t            s_in_red,
    input  wire hlsa_pkg::pix_t            s_in_green,
    input  wire hlsa_pkg::pix_t            s_in_blue,
    output logic                           m_valid,
    input  wire                            m_ready,
    output hlsa_pkg::pix_t                 m_out_red,
    output hlsa_pkg::pix_t                 m_out_green,
    output hlsa_pkg::pix_t                 m_out_blue
);
    import hlsa_pkg::*;

    logic [PCT_W-1:0] light_reg;
    logic [PCT_W-1:0] sat_reg;
    pct_t             pct;
    logic             wr_en;

    logic front_valid, front_ready;
    div_t front_data;
    logic div_valid, div_ready;
    hls_t div_data;
    logic adj_valid, adj_ready;
    hls_t adj_data;

    // register file write and read
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_reg <= '0;
            sat_reg   <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_LIGHT: light_reg <= pwdata[PCT_W-1:0];
                REG_SAT:   sat_reg   <= pwdata[PCT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LIGHT: prdata = DATA_W'(light_reg);
            REG_SAT:   prdata = DATA_W'(sat_reg);
            default:   prdata = '0;
        endcase
    end

    assign pct.light_pct = clamp_pct(light_reg);
    assign pct.sat_pct   = clamp_pct(sat_reg);

    hlsa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_red    (s_in_red),
        .in_green  (s_in_green),
        .in_blue   (s_in_blue),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    hlsa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    hlsa_adjust u_adjust (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pct       (pct),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (adj_valid),
        .out_ready (adj_ready),
        .out_data  (adj_data)
    );

    hlsa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (adj_valid),
        .in_ready  (adj_ready),
        .in_data   (adj_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_red   (m_out_red),
        .out_green (m_out_green),
        .out_blue  (m_out_blue)
    );

endmodule

`default_nettype wire

>>> sv/hlsa_front.sv
// rgb to max/min, lightness and divider operands, one register stage
// depends on hlsa_pkg
`default_nettype none

module hlsa_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire hlsa_pkg::pix_t  in_red,
    input  wire hlsa_pkg::pix_t  in_green,
    input  wire hlsa_pkg::pix_t  in_blue,
    output logic                 out_valid,
    input  wire                  out_ready,
    output hlsa_pkg::div_t       out_data
);
    import hlsa_pkg::*;

    logic  valid_reg;
    div_t  data_reg;
    div_t  data_next;
    logic  en;

    pix_t        mx;
    pix_t        mn;
    pix_t        dif;
    logic [8:0]  sum;
    logic [10:0] n;

    // stage advances when empty or when downstream takes its contents
    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // extremes, lightness and the two dividend/divisor pairs
    always_comb begin
        mx = in_red;
        mn = in_red;
        if (in_green > mx) mx = in_green;
        if (in_blue > mx)  mx = in_blue;
        if (in_green < mn) mn = in_green;
        if (in_blue < mn)  mn = in_blue;
        dif = mx - mn;
        sum = 9'(mx) + 9'(mn);

        // hue numerator, blue wins ties over green, green over red
        if (in_blue == mx) begin
            n = {1'b0, dif, 2'b00} + 11'(in_red) - 11'(in_green);
        end else if (in_green == mx) begin
            n = {2'b00, dif, 1'b0} + 11'(in_blue) - 11'(in_red);
        end else if (in_green > in_blue) begin
            n = 11'(in_green - in_blue);
        end else begin
            n = 11'(dif) * 11'd6 - 11'(in_blue - in_green);
        end

        data_next.light = sum[8:1];
        data_next.s_quo = '0;
        data_next.h_quo = '0;
        if (dif == 8'd0) begin
            // grey: zero quotients, unit divisors
            data_next.s_rem = '0;
            data_next.s_den = 9'd1;
            data_next.h_rem = '0;
            data_next.h_den = 9'd1;
        end else begin
            data_next.s_rem = NUM_W'(dif) * NUM_W'(255);
            data_next.s_den = (sum <= 9'd255) ? sum : 9'd510 - sum;
            data_next.h_rem = NUM_W'(n) * NUM_W'(85);
            data_next.h_den = {dif, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> sv/hlsa_div.sv
// pipelined restoring divider, one quotient bit per stage for saturation and hue
// depends on hlsa_pkg
`default_nettype none

module hlsa_div (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire hlsa_pkg::div_t  in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output hlsa_pkg::hls_t       out_data
);
    import hlsa_pkg::*;

    logic [QUO_W-1:0] valid_reg;
    div_t             stage_reg [QUO_W];
    logic [QUO_W:0]   en;

    assign en[QUO_W] = out_ready;
    assign in_ready  = en[0];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic prev_valid;
        div_t prev_data;

        if (i == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_data  = in_data;
        end else begin : g_rest
            assign prev_valid = valid_reg[i-1];
            assign prev_data  = stage_reg[i-1];
        end

        // ready chain: a stage moves when empty or when the next one moves
        assign en[i] = !valid_reg[i] || en[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en[i]) begin
                valid_reg[i] <= prev_valid;
            end
        end

        // quotient bit QUO_W-1-i
        always_ff @(posedge aclk) begin
            if (en[i]) begin
                stage_reg[i] <= div_step(prev_data, 3'(QUO_W - 1 - i));
            end
        end
    end

    assign out_valid      = valid_reg[QUO_W-1];
    assign out_data.light = stage_reg[QUO_W-1].light;
    assign out_data.sat   = stage_reg[QUO_W-1].s_quo;
    assign out_data.hue   = stage_reg[QUO_W-1].h_quo;

endmodule

`default_nettype wire

>>> sv/hlsa_adjust.sv
// percentage scaling of lightness and saturation, two register stages
// depends on hlsa_pkg
`default_nettype none

module hlsa_adjust (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire hlsa_pkg::pct_t  pct,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire hlsa_pkg::hls_t  in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output hlsa_pkg::hls_t       out_data
);
    import hlsa_pkg::*;

    typedef struct packed {
        logic [14:0] prod_l;
        logic [14:0] prod_s;
        pix_t        base_l;
        pix_t        base_s;
        pix_t        hue;
    } adj_t;

    logic [1:0] valid_reg;
    logic [2:0] en;
    adj_t       mul_reg;
    adj_t       mul_next;
    hls_t       res_reg;
    hls_t       res_next;

    logic [6:0] coef_l;
    logic [6:0] coef_s;
    pix_t       op_l;
    pix_t       op_s;
    logic [27:0] scaled_l;
    logic [27:0] scaled_s;

    assign en[2]    = out_ready;
    assign en[1]    = !valid_reg[1] || en[2];
    assign en[0]    = !valid_reg[0] || en[1];
    assign in_ready = en[0];

    // positive moves toward 255 from v, otherwise v is scaled by 100+p
    function automatic logic [6:0] coef_of(input logic signed [PCT_W-1:0] p);
        logic signed [PCT_W-1:0] c;
        c = (p > 8'sd0) ? p : 8'sd100 + p;
        return c[6:0];
    endfunction

    always_comb begin
        coef_l = coef_of(pct.light_pct);
        coef_s = coef_of(pct.sat_pct);
        op_l   = (pct.light_pct > 8'sd0) ? 8'd255 - in_data.light : in_data.light;
        op_s   = (pct.sat_pct > 8'sd0) ? 8'd255 - in_data.sat : in_data.sat;

        mul_next.prod_l = 15'(op_l) * 15'(coef_l);
        mul_next.prod_s = 15'(op_s) * 15'(coef_s);
        mul_next.base_l = (pct.light_pct > 8'sd0) ? in_data.light : 8'd0;
        mul_next.base_s = (pct.sat_pct > 8'sd0) ? in_data.sat : 8'd0;
        mul_next.hue    = in_data.hue;
    end

    // divide by 100 through the reciprocal
    always_comb begin
        scaled_l       = 28'(mul_reg.prod_l) * 28'(RECIP_100);
        scaled_s       = 28'(mul_reg.prod_s) * 28'(RECIP_100);
        res_next.light = mul_reg.base_l + scaled_l[SHIFT_100 +: PIX_W];
        res_next.sat   = mul_reg.base_s + scaled_s[SHIFT_100 +: PIX_W];
        res_next.hue   = mul_reg.hue;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= in_valid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) mul_reg <= mul_next;
        if (en[1]) res_reg <= res_next;
    end

    assign out_valid = valid_reg[1];
    assign out_data  = res_reg;

endmodule

`default_nettype wire

>>> sv/hlsa_back.sv
// hls to rgb conversion, seven register stages, last stage is the output register
// depends on hlsa_pkg
`default_nettype none

module hlsa_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire hlsa_pkg::hls_t  in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output hlsa_pkg::pix_t       out_red,
    output hlsa_pkg::pix_t       out_green,
    output hlsa_pkg::pix_t       out_blue
);
    import hlsa_pkg::*;

    localparam int NST = 7;

    typedef struct packed {
        pix_t        light;
        pix_t        sat;
        pix_t        hue;
        logic [15:0] ls;
    } b1_t;

    typedef struct packed {
        pix_t        light;
        logic        grey;
        pix_t        hue;
        logic [15:0] m2;
    } b2_t;

    typedef struct packed {
        pix_t            light;
        logic            grey;
        logic [15:0]     m1;
        logic [15:0]     m2;
        logic [15:0]     d;
        logic [2:0][1:0] seg;
        logic [2:0][5:0] slope;
    } b3_t;

    typedef struct packed {
        pix_t             light;
        logic             grey;
        logic [15:0]      m1;
        logic [15:0]      m2;
        logic [2:0][1:0]  seg;
        logic [2:0][22:0] prod;
    } b4_t;

    typedef struct packed {
        pix_t             light;
        logic             grey;
        logic [15:0]      m1;
        logic [15:0]      m2;
        logic [2:0][1:0]  seg;
        logic [2:0][15:0] q;
    } b5_t;

    typedef struct packed {
        pix_t             light;
        logic             grey;
        logic [2:0][15:0] t;
    } b6_t;

    logic [NST-1:0] valid_reg;
    logic [NST:0]   en;

    b1_t b1_reg, b1_next;
    b2_t b2_reg, b2_next;
    b3_t b3_reg, b3_next;
    b4_t b4_reg, b4_next;
    b5_t b5_reg, b5_next;
    b6_t b6_reg, b6_next;
    logic [2:0][7:0] rgb_reg, rgb_next;

    logic [17:0] m2_sum;
    logic [16:0] m1_full;
    logic [8:0]  k_red;
    pix_t        k_blue;
    pix_t [2:0]  k;
    logic [46:0] q_full [3];
    logic [16:0] t_sum  [3];
    logic [33:0] o_full [3];

    // ready chain over all stages
    assign en[NST] = out_ready;
    for (genvar i = 0; i < NST; i++) begin : g_en
        assign en[i] = !valid_reg[i] || en[i+1];
    end
    assign in_ready = en[0];

    // stage 1: l*s
    always_comb begin
        b1_next.light = in_data.light;
        b1_next.sat   = in_data.sat;
        b1_next.hue   = in_data.hue;
        b1_next.ls    = 16'(in_data.light) * 16'(in_data.sat);
    end

    // stage 2: m2 scaled by 255*255
    always_comb begin
        if (b1_reg.light <= 8'd127) begin
            m2_sum = 18'(b1_reg.light) * 18'd255 + 18'(b1_reg.ls);
        end else begin
            m2_sum = 18'(b1_reg.sat) * 18'd255 + 18'(b1_reg.light) * 18'd255
                     - 18'(b1_reg.ls);
        end
        b2_next.light = b1_reg.light;
        b2_next.grey  = (b1_reg.sat == 8'd0);
        b2_next.hue   = b1_reg.hue;
        b2_next.m2    = m2_sum[15:0];
    end

    // stage 3: m1, swing, channel angles and segments
    always_comb begin
        m1_full = 17'(b2_reg.light) * 17'd510 - 17'(b2_reg.m2);
        k_red   = 9'(b2_reg.hue) + 9'd85;
        if (k_red > 9'd255) begin
            k_red = k_red - 9'd255;
        end
        k_blue = (b2_reg.hue >= 8'd85) ? b2_reg.hue - 8'd85 : b2_reg.hue + 8'd170;
        k[0]   = k_red[7:0];
        k[1]   = b2_reg.hue;
        k[2]   = k_blue;

        b3_next.light = b2_reg.light;
        b3_next.grey  = b2_reg.grey;
        b3_next.m1    = m1_full[15:0];
        b3_next.m2    = b2_reg.m2;
        b3_next.d     = b2_reg.m2 - m1_full[15:0];
        for (int c = 0; c < 3; c++) begin
            b3_next.seg[c]   = seg_of(k[c]);
            b3_next.slope[c] = slope_of(k[c]);
        end
    end

    // stage 4: 2*slope*swing
    always_comb begin
        b4_next.light = b3_reg.light;
        b4_next.grey  = b3_reg.grey;
        b4_next.m1    = b3_reg.m1;
        b4_next.m2    = b3_reg.m2;
        b4_next.seg   = b3_reg.seg;
        for (int c = 0; c < 3; c++) begin
            b4_next.prod[c] = 23'({b3_reg.slope[c], 1'b0}) * 23'(b3_reg.d);
        end
    end

    // stage 5: divide by 85 through the reciprocal
    always_comb begin
        b5_next.light = b4_reg.light;
        b5_next.grey  = b4_reg.grey;
        b5_next.m1    = b4_reg.m1;
        b5_next.m2    = b4_reg.m2;
        b5_next.seg   = b4_reg.seg;
        for (int c = 0; c < 3; c++) begin
            q_full[c]    = 47'(b4_reg.prod[c]) * 47'(RECIP_85);
            b5_next.q[c] = q_full[c][SHIFT_85 +: 16];
        end
    end

    // stage 6: pick the channel value by segment
    always_comb begin
        b6_next.light = b5_reg.light;
        b6_next.grey  = b5_reg.grey;
        for (int c = 0; c < 3; c++) begin
            t_sum[c] = 17'(b5_reg.m1) + 17'(b5_reg.q[c]);
            case (b5_reg.seg[c]) inside
                SEG_RISE, SEG_FALL: b6_next.t[c] = t_sum[c][15:0];
                SEG_TOP:            b6_next.t[c] = b5_reg.m2;
                default:            b6_next.t[c] = b5_reg.m1;
            endcase
        end
    end

    // stage 7: divide by 255, grey when saturation is zero
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            o_full[c]   = 34'(b6_reg.t[c]) * 34'(RECIP_255);
            rgb_next[c] = b6_reg.grey ? b6_reg.light : o_full[c][SHIFT_255 +: PIX_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++) begin
                if (en[i]) valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) b1_reg  <= b1_next;
        if (en[1]) b2_reg  <= b2_next;
        if (en[2]) b3_reg  <= b3_next;
        if (en[3]) b4_reg  <= b4_next;
        if (en[4]) b5_reg  <= b5_next;
        if (en[5]) b6_reg  <= b6_next;
        if (en[6]) rgb_reg <= rgb_next;
    end

    assign out_valid = valid_reg[NST-1];
    assign out_red   = rgb_reg[0];
    assign out_green = rgb_reg[1];
    assign out_blue  = rgb_reg[2];

endmodule

`default_nettype wire

>>> sv/hlsa_check.sv
// port-level checker for the hls adjust top level, attached by bind
// depends on assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module hlsa_check (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input wire [7:0] m_out_red,
    input wire [7:0] m_out_green,
    input wire [7:0] m_out_blue
);

    logic [23:0] m_pix;

    assign m_pix = {m_out_red, m_out_green, m_out_blue};

    // a stalled result transaction stays offered
    `HLSA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid)

    // a stalled result keeps its pixel
    `HLSA_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_pix))

    // with the sink ready no stage can be blocked
    `HLSA_ASSERT_SAME(a_flow, m_ready, s_ready)

    // reset empties the pipeline
    `HLSA_ASSERT_RST(a_reset_empty, !aresetn, !m_valid)

endmodule

bind rgb_hls_lightness_saturation_adjust_top hlsa_check u_hlsa_check (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_red   (m_out_red),
    .m_out_green (m_out_green),
    .m_out_blue  (m_out_blue)
);

`default_nettype wire
